// File: rtl/core/ctp_pkg.sv
// Package for the chunky-to-planar converter.
// Shared constants, register map codes and the structs between the core modules.
// No dependencies.
`default_nettype none

package ctp_pkg;

	// fixed field widths
	localparam int PIX_W      = 8;
	localparam int DATA_W     = 8;
	localparam int ADDR_W     = 20;
	localparam int PADDR_W    = 4;
	localparam int PDATA_W    = 32;
	localparam int BW_REG_W   = 8;
	localparam int ROWS_REG_W = 11;
	localparam int NP_REG_W   = 4;

	// one byte per plane holds eight pixels, leftmost in the top bit
	localparam int GROUP_PIXELS = 8;
	localparam int TOP_BIT      = 7;

	// default sizes
	localparam int DEF_MAX_BYTE_WIDTH = 128;
	localparam int DEF_MAX_ROWS       = 1024;
	localparam int DEF_MAX_PLANES     = 8;
	localparam int DEF_TABLE_DEPTH    = 256;

	// register reset values
	localparam logic [BW_REG_W-1:0]   RST_BYTE_WIDTH  = 8'd40;
	localparam logic [ROWS_REG_W-1:0] RST_ROWS        = 11'd256;
	localparam logic [NP_REG_W-1:0]   RST_PLANE_COUNT = 4'd5;
	localparam logic                  RST_INTERLEAVED = 1'b0;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_PIXEL = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		REG_BYTE_WIDTH  = 2'd0,
		REG_ROWS        = 2'd1,
		REG_PLANE_COUNT = 2'd2,
		REG_INTERLEAVED = 2'd3
	} reg_idx_t;

	// remapped pixel waiting in the first stage
	typedef struct packed {
		logic              valid;
		logic [DATA_W-1:0] mapped;
	} pix_s1_t;

	// emitter status towards the gather stage
	typedef struct packed {
		logic free;
		logic busy;
	} emit_stat_t;

	// address strides and plane count, derived from the registers
	typedef struct packed {
		logic [ADDR_W-1:0]   row_stride;
		logic [ADDR_W-1:0]   plane_stride;
		logic [NP_REG_W-1:0] planes;
	} emit_cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [DATA_W-1:0] data;
		logic              last;
	} result_t;

endpackage

`default_nettype wire

// File: rtl/core/ctp_intf.sv
// Stream interfaces of the chunky-to-planar converter: input items and plane bytes.
// Depends on ctp_pkg.
`default_nettype none

interface ctp_item_if import ctp_pkg::*; ();
	logic             valid;
	logic             ready;
	logic             op;
	logic [PIX_W-1:0] map_index;
	logic [PIX_W-1:0] map_value;
	logic [PIX_W-1:0] pixel_index;

	modport source(output valid, op, map_index, map_value, pixel_index, input ready);
	modport sink(input valid, op, map_index, map_value, pixel_index, output ready);
endinterface

interface ctp_result_if import ctp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [ADDR_W-1:0] byte_address;
	logic [DATA_W-1:0] plane_byte;
	logic              last;

	modport source(output valid, byte_address, plane_byte, last, input ready);
	modport sink(input valid, byte_address, plane_byte, last, output ready);
endinterface

`default_nettype wire

// File: rtl/core/ctp_table.sv
// Palette reorder table: synchronous memory written by load items, read by pixels.
// Holds the first pipeline stage. Depends on ctp_pkg and ctp_intf.
`default_nettype none

module ctp_table import ctp_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	ctp_item_if.sink     items,
	input  wire logic    s1_adv,
	output pix_s1_t      s1
);

	localparam int TAB_W = $clog2(TABLE_DEPTH);

	logic [DATA_W-1:0] mem [TABLE_DEPTH];
	logic              accept;
	logic              valid_s1;
	logic              hit_s1;
	logic [DATA_W-1:0] rdata_s1;

	assign items.ready = !valid_s1 || s1_adv;
	assign accept      = items.valid && items.ready;

	// write lands at the accept edge, so a pixel in the next cycle reads it
	always_ff @(posedge clk) begin
		if (accept && items.op == OP_LOAD && 32'(items.map_index) < TABLE_DEPTH) begin
			mem[items.map_index[TAB_W-1:0]] <= items.map_value;
		end
		if (accept && items.op == OP_PIXEL) begin
			rdata_s1 <= mem[items.pixel_index[TAB_W-1:0]];
			hit_s1   <= 32'(items.pixel_index) < TABLE_DEPTH;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid && items.op == OP_PIXEL;
		end
	end

	assign s1.valid  = valid_s1;
	assign s1.mapped = hit_s1 ? rdata_s1 : '0;

endmodule

`default_nettype wire

// File: rtl/core/ctp_gather.sv
// Bitplane gather: per-plane byte accumulators and the pixel, column and row counters.
// Hands a finished group to the emitter. Depends on ctp_pkg.
`default_nettype none

module ctp_gather import ctp_pkg::*; #(
	parameter  int MAX_BYTE_WIDTH = DEF_MAX_BYTE_WIDTH,
	parameter  int MAX_ROWS       = DEF_MAX_ROWS,
	parameter  int MAX_PLANES     = DEF_MAX_PLANES,
	localparam int BW_W  = $clog2(MAX_BYTE_WIDTH + 1),
	localparam int NR_W  = $clog2(MAX_ROWS + 1),
	localparam int COL_W = $clog2(MAX_BYTE_WIDTH),
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire pix_s1_t                      s1,
	input  wire emit_stat_t                   emit_st,
	input  wire logic [BW_W-1:0]              bw,
	input  wire logic [NR_W-1:0]              nr,
	output logic                              s1_adv,
	output logic                              grp_load,
	output logic [MAX_PLANES-1:0][DATA_W-1:0] grp_bits,
	output logic [ROW_W-1:0]                  grp_row,
	output logic [COL_W-1:0]                  grp_col
);

	logic [MAX_PLANES-1:0][DATA_W-1:0] acc_q;
	logic [MAX_PLANES-1:0][DATA_W-1:0] acc_next;
	logic [2:0]                        pig_q;
	logic [COL_W-1:0]                  col_q;
	logic [ROW_W-1:0]                  row_q;
	logic                              completing;
	logic                              col_wrap;
	logic                              row_wrap;

	assign completing = pig_q == 3'(TOP_BIT);

	always_comb begin
		for (int p = 0; p < MAX_PLANES; p++) begin
			acc_next[p] = acc_q[p] | (DATA_W'(s1.mapped[p]) << (3'(TOP_BIT) - pig_q));
		end
	end

	// a finished group waits in this stage until the emitter can take it
	assign s1_adv   = s1.valid && (!completing || emit_st.free);
	assign grp_load = s1_adv && completing;
	assign grp_bits = acc_next;
	assign grp_row  = row_q;
	assign grp_col  = col_q;

	// limits may have shrunk below the counter; it then wraps on its next step
	assign col_wrap = 32'(col_q) + 32'd1 >= 32'(bw);
	assign row_wrap = 32'(row_q) + 32'd1 >= 32'(nr);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pig_q <= '0;
			col_q <= '0;
			row_q <= '0;
		end else if (s1_adv) begin
			if (completing) begin
				acc_q <= '0;
				pig_q <= '0;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= row_wrap ? '0 : row_q + 1'b1;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else begin
				acc_q <= acc_next;
				pig_q <= pig_q + 3'd1;
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/core/ctp_emit.sv
// Plane emitter: steps through the planes of a group, forms byte addresses and
// queues the plane bytes in a short output queue. Depends on ctp_pkg and ctp_intf.
`default_nettype none

module ctp_emit import ctp_pkg::*; #(
	parameter  int MAX_BYTE_WIDTH = DEF_MAX_BYTE_WIDTH,
	parameter  int MAX_ROWS       = DEF_MAX_ROWS,
	parameter  int MAX_PLANES     = DEF_MAX_PLANES,
	localparam int COL_W = $clog2(MAX_BYTE_WIDTH),
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire emit_cfg_t                         cfg,
	input  wire logic                              grp_load,
	input  wire logic [MAX_PLANES-1:0][DATA_W-1:0] grp_bits,
	input  wire logic [ROW_W-1:0]                  grp_row,
	input  wire logic [COL_W-1:0]                  grp_col,
	output emit_stat_t                             st,
	ctp_result_if.source                           results
);

	localparam int PL_W       = (MAX_PLANES > 1) ? $clog2(MAX_PLANES) : 1;
	localparam int OUTQ_DEPTH = 2;
	localparam int OQ_W       = $clog2(OUTQ_DEPTH);
	localparam int PROD_W     = ROW_W + ADDR_W;

	logic                              busy_q;
	logic [PL_W-1:0]                   plane_q;
	logic [MAX_PLANES-1:0][DATA_W-1:0] snap_q;
	logic [ADDR_W-1:0]                 addr_q;
	result_t                           q_q [OUTQ_DEPTH];
	logic [OQ_W-1:0]                   wr_q;
	logic [OQ_W-1:0]                   rd_q;
	logic [OQ_W:0]                     cnt_q;
	logic                              push;
	logic                              pop;
	logic                              last_plane;
	logic [PROD_W-1:0]                 row_prod;
	logic [ADDR_W-1:0]                 base;

	assign row_prod   = PROD_W'(grp_row) * PROD_W'(cfg.row_stride);
	assign base       = row_prod[ADDR_W-1:0] + ADDR_W'(grp_col);

	assign last_plane = NP_REG_W'(plane_q) + NP_REG_W'(1) == cfg.planes;
	assign push       = busy_q && cnt_q != (OQ_W + 1)'(OUTQ_DEPTH);
	assign pop        = results.valid && results.ready;

	// free decided from registered emitter and queue state only
	assign st.free = !busy_q || (push && last_plane);
	assign st.busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			plane_q <= '0;
			wr_q    <= '0;
			rd_q    <= '0;
			cnt_q   <= '0;
		end else begin
			if (grp_load) begin
				busy_q  <= 1'b1;
				plane_q <= '0;
			end else if (push) begin
				plane_q <= plane_q + 1'b1;
				if (last_plane) begin
					busy_q <= 1'b0;
				end
			end
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			cnt_q <= cnt_q + (OQ_W + 1)'(push) - (OQ_W + 1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			snap_q <= grp_bits;
			addr_q <= base;
		end else if (push) begin
			addr_q <= addr_q + cfg.plane_stride;
		end
		if (push) begin
			q_q[wr_q] <= '{addr: addr_q, data: snap_q[plane_q], last: last_plane};
		end
	end

	assign results.valid        = cnt_q != '0;
	assign results.byte_address = q_q[rd_q].addr;
	assign results.plane_byte   = q_q[rd_q].data;
	assign results.last         = q_q[rd_q].last;

endmodule

`default_nettype wire

// File: rtl/core/chunky_to_planar_converter.sv
// Chunky-to-planar converter: 1 item per cycle in when not stalled; the eighth pixel
// passes first stage, emitter and queue, then one plane byte per cycle while accepted.
// Rate is set by the single table read per cycle and the one-byte-per-cycle emitter.
// Reset clears counters, accumulators, pipeline and queue, and loads register defaults;
// the reorder table holds nothing defined until loaded, and has no clearing pass.
// Depends on ctp_pkg, ctp_intf, ctp_table, ctp_gather and ctp_emit.
`default_nettype none

module chunky_to_planar_converter import ctp_pkg::*; #(
	parameter int MAX_BYTE_WIDTH = DEF_MAX_BYTE_WIDTH,
	parameter int MAX_ROWS       = DEF_MAX_ROWS,
	parameter int MAX_PLANES     = DEF_MAX_PLANES,
	parameter int TABLE_DEPTH    = DEF_TABLE_DEPTH
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	ctp_item_if.sink                items,
	ctp_result_if.source            results,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	output logic      [PDATA_W-1:0] prdata,
	output logic                    pready
);

	localparam int BW_W  = $clog2(MAX_BYTE_WIDTH + 1);
	localparam int NR_W  = $clog2(MAX_ROWS + 1);
	localparam int COL_W = $clog2(MAX_BYTE_WIDTH);
	localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	logic [BW_REG_W-1:0]   byte_width_q;
	logic [ROWS_REG_W-1:0] rows_q;
	logic [NP_REG_W-1:0]   plane_count_q;
	logic                  interleaved_q;
	logic                  cfg_wr;
	reg_idx_t              reg_idx;

	logic [BW_W-1:0]             bw_c;
	logic [NR_W-1:0]             nr_c;
	logic [NP_REG_W-1:0]         np_c;
	logic [NP_REG_W+BW_W-1:0]    npbw;
	logic [NR_W+BW_W-1:0]        nrbw;
	emit_cfg_t                   cfg_q;

	pix_s1_t                           s1;
	emit_stat_t                        emit_st;
	logic                              s1_adv;
	logic                              grp_load;
	logic [MAX_PLANES-1:0][DATA_W-1:0] grp_bits;
	logic [ROW_W-1:0]                  grp_row;
	logic [COL_W-1:0]                  grp_col;

	// register file
	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_width_q  <= RST_BYTE_WIDTH;
			rows_q        <= RST_ROWS;
			plane_count_q <= RST_PLANE_COUNT;
			interleaved_q <= RST_INTERLEAVED;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_BYTE_WIDTH:  byte_width_q  <= pwdata[BW_REG_W-1:0];
				REG_ROWS:        rows_q        <= pwdata[ROWS_REG_W-1:0];
				REG_PLANE_COUNT: plane_count_q <= pwdata[NP_REG_W-1:0];
				REG_INTERLEAVED: interleaved_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BYTE_WIDTH:  prdata = PDATA_W'(byte_width_q);
			REG_ROWS:        prdata = PDATA_W'(rows_q);
			REG_PLANE_COUNT: prdata = PDATA_W'(plane_count_q);
			REG_INTERLEAVED: prdata = PDATA_W'(interleaved_q);
			default:         prdata = '0;
		endcase
	end

	// registers saturate into their usable range
	always_comb begin
		if (byte_width_q == '0) begin
			bw_c = BW_W'(1);
		end else if (32'(byte_width_q) > MAX_BYTE_WIDTH) begin
			bw_c = BW_W'(MAX_BYTE_WIDTH);
		end else begin
			bw_c = BW_W'(byte_width_q);
		end
		if (rows_q == '0) begin
			nr_c = NR_W'(1);
		end else if (32'(rows_q) > MAX_ROWS) begin
			nr_c = NR_W'(MAX_ROWS);
		end else begin
			nr_c = NR_W'(rows_q);
		end
		if (plane_count_q == '0) begin
			np_c = NP_REG_W'(1);
		end else if (32'(plane_count_q) > MAX_PLANES) begin
			np_c = NP_REG_W'(MAX_PLANES);
		end else begin
			np_c = plane_count_q;
		end
	end

	assign npbw = (NP_REG_W + BW_W)'(np_c) * (NP_REG_W + BW_W)'(bw_c);
	assign nrbw = (NR_W + BW_W)'(nr_c) * (NR_W + BW_W)'(bw_c);

	// strides are registered, settling in the cycle after a register write
	always_ff @(posedge clk) begin
		cfg_q.row_stride   <= interleaved_q ? ADDR_W'(npbw) : ADDR_W'(bw_c);
		cfg_q.plane_stride <= interleaved_q ? ADDR_W'(bw_c) : ADDR_W'(nrbw);
		cfg_q.planes       <= np_c;
	end

	ctp_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.items  (items),
		.s1_adv (s1_adv),
		.s1     (s1)
	);

	ctp_gather #(
		.MAX_BYTE_WIDTH(MAX_BYTE_WIDTH),
		.MAX_ROWS      (MAX_ROWS),
		.MAX_PLANES    (MAX_PLANES)
	) u_gather (
		.clk      (clk),
		.arst_n   (arst_n),
		.s1       (s1),
		.emit_st  (emit_st),
		.bw       (bw_c),
		.nr       (nr_c),
		.s1_adv   (s1_adv),
		.grp_load (grp_load),
		.grp_bits (grp_bits),
		.grp_row  (grp_row),
		.grp_col  (grp_col)
	);

	ctp_emit #(
		.MAX_BYTE_WIDTH(MAX_BYTE_WIDTH),
		.MAX_ROWS      (MAX_ROWS),
		.MAX_PLANES    (MAX_PLANES)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.grp_load (grp_load),
		.grp_bits (grp_bits),
		.grp_row  (grp_row),
		.grp_col  (grp_col),
		.st       (emit_st),
		.results  (results)
	);

	// a pixel transfer always lands in the first stage
	a_pixel_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready && items.op == OP_PIXEL |=> s1.valid)
		else $error("pixel transfer did not reach first stage");

	// input held off only by a finished group waiting on a busy emitter
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		s1.valid && !items.ready |-> !emit_st.free)
		else $error("input stalled while emitter free");

	// a handed-over group keeps the emitter busy for at least one plane
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		grp_load |=> emit_st.busy)
		else $error("emitter idle after group handover");

endmodule

`default_nettype wire
